[rtl/ats_pkg.sv]
// Package for the tilt-to-servo block: frame layout, job record, tan table.
// No dependencies; used by the front end, queue, back end, top level, checker and testbench.
`timescale 1ns / 1ps
package ats_pkg;

    localparam int FRAME_BYTES = 6;
    localparam int POS_W       = 3;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

    localparam int MAG_W   = 16;
    localparam int SERVO_W = 12;
    localparam int GAIN_W  = 4;
    localparam logic [SERVO_W-1:0] SERVO_MAX  = 12'd4095;
    localparam logic [SERVO_W-1:0] HOLD_RESET = 12'd2000;
    localparam logic [SERVO_W-1:0] CENTER_RST = 12'd2000;
    localparam logic [GAIN_W-1:0]  GAIN_RST   = 4'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'd1;

    // tan(k deg) in unsigned Q16.16, k = 1..89, stored at k-1
    localparam int TAN_ENTRIES = 89;
    localparam int TAN_W  = 22;
    localparam int K_W    = 7;
    localparam int PROD_W = TAN_W + MAG_W;

    localparam logic [TAN_W-1:0] TAN_Q16 [0:TAN_ENTRIES-1] = '{
        22'd1144, 22'd2289, 22'd3435, 22'd4583, 22'd5734, 22'd6888, 22'd8047, 22'd9210,
        22'd10380, 22'd11556, 22'd12739, 22'd13930, 22'd15130, 22'd16340, 22'd17560,
        22'd18792, 22'd20036, 22'd21294, 22'd22566, 22'd23853, 22'd25157, 22'd26478,
        22'd27818, 22'd29179, 22'd30560, 22'd31964, 22'd33392, 22'd34846, 22'd36327,
        22'd37837, 22'd39378, 22'd40951, 22'd42560, 22'd44205, 22'd45889, 22'd47615,
        22'd49385, 22'd51202, 22'd53070, 22'd54991, 22'd56970, 22'd59009, 22'd61113,
        22'd63287, 22'd65536, 22'd67865, 22'd70279, 22'd72785, 22'd75391, 22'd78103,
        22'd80930, 22'd83882, 22'd86969, 22'd90203, 22'd93595, 22'd97161, 22'd100917,
        22'd104880, 22'd109070, 22'd113512, 22'd118230, 22'd123255, 22'd128622,
        22'd134369, 22'd140542, 22'd147196, 22'd154393, 22'd162207, 22'd170727,
        22'd180059, 22'd190330, 22'd201699, 22'd214359, 22'd228551, 22'd244584,
        22'd262851, 22'd283868, 22'd308323, 22'd337153, 22'd371673, 22'd413778,
        22'd466313, 22'd533748, 22'd623533, 22'd749080, 22'd937208, 22'd1250501,
        22'd1876705, 22'd3754555
    };

    // One assembled frame, handed from front to back
    typedef struct packed {
        logic             x_neg;
        logic             y_neg;
        logic             z_neg;
        logic [MAG_W-1:0] x_mag;
        logic [MAG_W-1:0] y_mag;
        logic [MAG_W-1:0] z_mag;
    } t_job;

    localparam int Q_DEPTH = 2;

endpackage

[rtl/ats_byte_if.sv]
// Byte channel into the tilt-to-servo block: valid/ready plus one sensor byte.
// No dependencies.
`timescale 1ns / 1ps
interface ats_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/ats_servo_if.sv]
// Result channel of the tilt-to-servo block: valid/ready plus two setpoints.
// No dependencies.
`timescale 1ns / 1ps
interface ats_servo_if;
    logic        valid;
    logic        ready;
    logic [11:0] servo_one;
    logic [11:0] servo_two;
    logic        updated;

    modport source (output valid, output servo_one, output servo_two, output updated,
                    input ready);
    modport sink   (input valid, input servo_one, input servo_two, input updated,
                    output ready);
endinterface

[rtl/ats_front.sv]
// Front end: collects six sensor bytes, forms sign/magnitude per axis, pushes a job.
// Depends on ats_pkg.
`timescale 1ns / 1ps
module ats_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_job_valid,
    input  logic                 i_job_ready,
    output ats_pkg::t_job        o_job
);
    import ats_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_bytes [0:FRAME_BYTES-2];
    logic             last;
    logic             accept;

    function automatic logic [MAG_W:0] axis_mag(input logic [7:0] lo, input logic [7:0] hi);
        logic [MAG_W-1:0] w;
        logic [MAG_W-1:0] a;
        begin
            w = {hi, lo};
            a = w[MAG_W-1] ? (MAG_W'(0) - w) : w;
            // times four, wrapping at 16 bits
            axis_mag = {w[MAG_W-1], a[MAG_W-3:0], 2'b00};
        end
    endfunction

    logic [MAG_W:0] xm, ym, zm;

    assign last        = (r_pos == POS_LAST);
    assign o_ready     = !last || i_job_ready;
    assign accept      = i_valid && o_ready;
    assign o_job_valid = i_valid && last;

    assign xm = axis_mag(r_bytes[0], r_bytes[1]);
    assign ym = axis_mag(r_bytes[2], r_bytes[3]);
    assign zm = axis_mag(r_bytes[4], i_rx_byte);

    always_comb begin
        o_job.x_neg = xm[MAG_W];
        o_job.y_neg = ym[MAG_W];
        o_job.z_neg = zm[MAG_W];
        o_job.x_mag = xm[MAG_W-1:0];
        o_job.y_mag = ym[MAG_W-1:0];
        o_job.z_mag = zm[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= last ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !last) begin
            r_bytes[r_pos] <= i_rx_byte;
        end
    end

endmodule

[rtl/ats_queue.sv]
// Two-entry job queue between the byte front end and the angle back end.
// Depends on ats_pkg.
`timescale 1ns / 1ps
module ats_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ats_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ats_pkg::t_job o_pop_job
);
    import ats_pkg::*;

    localparam int QA = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC = $clog2(Q_DEPTH + 1);

    t_job            r_mem [0:Q_DEPTH-1];
    logic [QA-1:0]   r_wr;
    logic [QA-1:0]   r_rd;
    logic [QC-1:0]   r_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != QC'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QA'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QA'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QC'(push) - QC'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

[rtl/ats_back.sv]
// Back end: binary search of the tan table for both tilt angles, then setpoint
// scaling, saturation and the output register; a negative z resends the held setpoints. Depends on ats_pkg.
`timescale 1ns / 1ps
module ats_back #(
    parameter int ANGLE_STEPS = 90
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  ats_pkg::t_job                 i_job,
    input  logic [ats_pkg::SERVO_W-1:0]   i_center,
    input  logic [ats_pkg::GAIN_W-1:0]    i_gain,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ats_pkg::SERVO_W-1:0]   o_servo_one,
    output logic [ats_pkg::SERVO_W-1:0]   o_servo_two,
    output logic                          o_updated
);
    import ats_pkg::*;

    localparam int AW = $clog2(ANGLE_STEPS + 1);
    // highest angle the search can return
    localparam int BOUND = (ANGLE_STEPS - 1 < TAN_ENTRIES) ? ANGLE_STEPS - 1 : TAN_ENTRIES;
    localparam int SW = SERVO_W + GAIN_W + AW + 1;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_CMP, S_SCALE, S_OUT} t_state;

    t_state              r_state;
    t_job                r_job;
    logic [K_W-1:0]      r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic [K_W-1:0]      r_mid_x, r_mid_y;
    logic [PROD_W-1:0]   r_prod_x, r_prod_y;
    logic [AW-1:0]       r_ang_x, r_ang_y;
    logic [SERVO_W-1:0]  r_hold_one, r_hold_two;

    logic [K_W-1:0]      mid_x, mid_y, idx_x, idx_y;
    logic                ge_x, ge_y;
    logic [K_W-1:0]      n_lo_x, n_hi_x, n_lo_y, n_hi_y;
    logic [SW-1:0]       sum_one, sum_two;
    logic [SERVO_W-1:0]  sat_one, sat_two;

    function automatic logic [SERVO_W-1:0] clamp(input logic [SW-1:0] v);
        begin
            if (v[SW-1]) begin
                clamp = '0;
            end else if (v > SW'(SERVO_MAX)) begin
                clamp = SERVO_MAX;
            end else begin
                clamp = v[SERVO_W-1:0];
            end
        end
    endfunction

    assign mid_x = K_W'((K_W+1)'(r_lo_x) + (K_W+1)'(r_hi_x) + 1'b1 >> 1);
    assign mid_y = K_W'((K_W+1)'(r_lo_y) + (K_W+1)'(r_hi_y) + 1'b1 >> 1);
    assign idx_x = (mid_x == '0) ? '0 : mid_x - 1'b1;
    assign idx_y = (mid_y == '0) ? '0 : mid_y - 1'b1;

    assign ge_x = ((PROD_W'(r_job.x_mag) << 16) >= r_prod_x);
    assign ge_y = ((PROD_W'(r_job.y_mag) << 16) >= r_prod_y);

    always_comb begin
        n_lo_x = r_lo_x;
        n_hi_x = r_hi_x;
        n_lo_y = r_lo_y;
        n_hi_y = r_hi_y;
        if (r_lo_x < r_hi_x) begin
            if (ge_x) n_lo_x = r_mid_x;
            else      n_hi_x = r_mid_x - 1'b1;
        end
        if (r_lo_y < r_hi_y) begin
            if (ge_y) n_lo_y = r_mid_y;
            else      n_hi_y = r_mid_y - 1'b1;
        end
    end

    // x tilt moves servo one the other way from y tilt on servo two
    assign sum_one = r_job.x_neg ? SW'(i_center) + SW'(i_gain) * SW'(r_ang_x)
                                 : SW'(i_center) - SW'(i_gain) * SW'(r_ang_x);
    assign sum_two = r_job.y_neg ? SW'(i_center) - SW'(i_gain) * SW'(r_ang_y)
                                 : SW'(i_center) + SW'(i_gain) * SW'(r_ang_y);
    assign sat_one = clamp(sum_one);
    assign sat_two = clamp(sum_two);

    assign o_job_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            o_valid    <= 1'b0;
            r_hold_one <= HOLD_RESET;
            r_hold_two <= HOLD_RESET;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        if (i_job.z_neg) begin
                            o_servo_one <= r_hold_one;
                            o_servo_two <= r_hold_two;
                            o_updated   <= 1'b0;
                            o_valid     <= 1'b1;
                            r_state     <= S_OUT;
                        end else if (i_job.z_mag == '0) begin
                            r_ang_x <= (i_job.x_mag == '0) ? '0 : AW'(ANGLE_STEPS);
                            r_ang_y <= (i_job.y_mag == '0) ? '0 : AW'(ANGLE_STEPS);
                            r_state <= S_SCALE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (n_lo_x == n_hi_x && n_lo_y == n_hi_y) begin
                        r_ang_x <= AW'(n_lo_x);
                        r_ang_y <= AW'(n_lo_y);
                        r_state <= S_SCALE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_SCALE: begin
                    r_hold_one  <= sat_one;
                    r_hold_two  <= sat_two;
                    o_servo_one <= sat_one;
                    o_servo_two <= sat_two;
                    o_updated   <= 1'b1;
                    o_valid     <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Search datapath: bounds, midpoint and the registered table product
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            r_job  <= i_job;
            r_lo_x <= '0;
            r_lo_y <= '0;
            r_hi_x <= K_W'(BOUND);
            r_hi_y <= K_W'(BOUND);
        end
        if (r_state == S_MUL) begin
            r_mid_x  <= mid_x;
            r_mid_y  <= mid_y;
            r_prod_x <= PROD_W'(TAN_Q16[idx_x]) * PROD_W'(r_job.z_mag);
            r_prod_y <= PROD_W'(TAN_Q16[idx_y]) * PROD_W'(r_job.z_mag);
        end
        if (r_state == S_CMP) begin
            r_lo_x <= n_lo_x;
            r_hi_x <= n_hi_x;
            r_lo_y <= n_lo_y;
            r_hi_y <= n_hi_y;
        end
    end

endmodule

[rtl/accel_tilt_to_servo_core.sv]
// Top level of the accelerometer tilt to servo setpoint block.
// Depends on ats_pkg, ats_byte_if, ats_servo_if, ats_front, ats_queue, ats_back.
//
//   channel   | dir | payload                          | accepted when
//   ----------+-----+----------------------------------+----------------------
//   i_byte    | in  | rx_byte[7:0]                     | valid && ready
//   o_servo   | out | servo_one[11:0] servo_two[11:0]  | valid && ready
//             |     | updated                          |
//   i_cfg_*   | in  | idx 0 center[11:0], idx 1 gain   | i_cfg_we
//
// Bytes are taken one per cycle; a frame's sixth byte waits only while the
// two-entry job queue is full. Each frame gives one item. The back end runs a
// binary search over the tan table for both axes at once, each step a table
// product, then a compare, up to 7 steps for 90 angle steps. A zero z skips the
// search and a negative z resends the held setpoints. A stalled output holds
// the back end; the queue keeps the front end going.
// Reset (synchronous, active low) clears the byte count, queue, back-end state
// and loads the setpoint holds and registers with their defaults.
`timescale 1ns / 1ps
module accel_tilt_to_servo_core #(
    parameter int ANGLE_STEPS = 90
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ats_byte_if.sink                        i_byte,
    ats_servo_if.source                     o_servo,
    input  logic                            i_cfg_we,
    input  logic [ats_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ats_pkg::SERVO_W-1:0]     i_cfg_data
);
    import ats_pkg::*;

    logic [SERVO_W-1:0] r_center;
    logic [GAIN_W-1:0]  r_gain;

    logic  f_job_valid, f_job_ready;
    t_job  f_job;
    logic  b_job_valid, b_job_ready;
    t_job  b_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RST;
            r_gain   <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER: r_center <= i_cfg_data;
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    ats_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_byte.valid),
        .o_ready     (i_byte.ready),
        .i_rx_byte   (i_byte.rx_byte),
        .o_job_valid (f_job_valid),
        .i_job_ready (f_job_ready),
        .o_job       (f_job)
    );

    ats_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_job_valid),
        .o_push_ready (f_job_ready),
        .i_push_job   (f_job),
        .o_pop_valid  (b_job_valid),
        .i_pop_ready  (b_job_ready),
        .o_pop_job    (b_job)
    );

    ats_back #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (b_job_valid),
        .o_job_ready (b_job_ready),
        .i_job       (b_job),
        .i_center    (r_center),
        .i_gain      (r_gain),
        .o_valid     (o_servo.valid),
        .i_ready     (o_servo.ready),
        .o_servo_one (o_servo.servo_one),
        .o_servo_two (o_servo.servo_two),
        .o_updated   (o_servo.updated)
    );

endmodule

[rtl/ats_checker.sv]
// Port-level checks for accel_tilt_to_servo_core, attached by bind.
// Depends on ats_pkg and the top level's ports.
`timescale 1ns / 1ps
module ats_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ats_pkg::SERVO_W-1:0]   i_servo_one,
    input logic [ats_pkg::SERVO_W-1:0]   i_servo_two,
    input logic                          i_updated
);
    import ats_pkg::*;

    logic [POS_W-1:0]   r_pos;
    logic [2:0]         r_pend;
    logic [SERVO_W-1:0] r_last_one, r_last_two;
    logic               in_acc, out_acc, frame_done;

    assign in_acc     = i_in_valid && i_in_ready;
    assign out_acc    = i_out_valid && i_out_ready;
    assign frame_done = in_acc && (r_pos == POS_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_pend     <= '0;
            r_last_one <= HOLD_RESET;
            r_last_two <= HOLD_RESET;
        end else begin
            if (in_acc) begin
                r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
            end
            r_pend <= r_pend + 3'(frame_done) - 3'(out_acc);
            if (out_acc) begin
                r_last_one <= i_servo_one;
                r_last_two <= i_servo_two;
            end
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_servo_one) && $stable(i_servo_two) && $stable(i_updated))
        else $error("result payload changed while stalled");

    a_no_extra_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pend != 3'd0)
        else $error("result delivered without a completed frame");

    a_held_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !i_updated |-> i_servo_one == r_last_one && i_servo_two == r_last_two)
        else $error("held result differs from previous setpoints");

endmodule

bind accel_tilt_to_servo_core ats_checker u_ats_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_servo.valid),
    .i_out_ready (o_servo.ready),
    .i_servo_one (o_servo.servo_one),
    .i_servo_two (o_servo.servo_two),
    .i_updated   (o_servo.updated)
);

[test/accel_tilt_to_servo_core_test.sv]
// Testbench for accel_tilt_to_servo_core: byte frames in, servo setpoints out.
// Depends on ats_pkg, ats_byte_if, ats_servo_if and the core; checks every result
// item against an in-bench setpoint predictor or the directed table's setpoints.
`timescale 1ns / 1ps
module accel_tilt_to_servo_core_test;

    localparam int ANGLE_STEPS   = 90;
    localparam int TAN_COUNT     = 89;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_BYTES   = 120;

    // tan(k deg), k = 1..89, unsigned Q16.16
    localparam int unsigned TAN_TBL [TAN_COUNT] = '{
        1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380, 11556,
        12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294, 22566, 23853,
        25157, 26478, 27818, 29179, 30560, 31964, 33392, 34846, 36327, 37837,
        39378, 40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070, 54991,
        56970, 59009, 61113, 63287, 65536, 67865, 70279, 72785, 75391, 78103,
        80930, 83882, 86969, 90203, 93595, 97161, 100917, 104880, 109070, 113512,
        118230, 123255, 128622, 134369, 140542, 147196, 154393, 162207, 170727, 180059,
        190330, 201699, 214359, 228551, 244584, 262851, 283868, 308323, 337153, 371673,
        413778, 466313, 533748, 623533, 749080, 937208, 1250501, 1876705, 3754555
    };

    typedef struct packed {
        logic [11:0] servo_one;
        logic [11:0] servo_two;
        logic        updated;
    } t_setpoint;

    typedef struct packed {
        logic [7:0]  rx;
        logic        typed;
        t_setpoint   sp;
    } t_dir_row;

    // Four frames: all zero, zero z magnitude (wrapped z and wrapped y),
    // negative z hold, and a 45 degree tilt on both axes.
    localparam t_dir_row DIR_ROWS [24] = '{
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{12'd2000, 12'd2000, 1'b1}},
        '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h40, 1'b1, '{12'd1730, 12'd2000, 1'b1}},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'h7F, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{12'd1730, 12'd2000, 1'b0}},
        '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ats_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [ats_pkg::SERVO_W-1:0]   i_cfg_data;

    ats_byte_if  byte_ch ();
    ats_servo_if servo_ch ();

    accel_tilt_to_servo_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_ch),
        .o_servo    (servo_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predictor state
    int          frame_pos;
    logic [7:0]  frame_store [5];
    logic [11:0] hold_one;
    logic [11:0] hold_two;
    logic [11:0] cur_center;
    logic [3:0]  cur_gain;

    t_setpoint pending_setpoints [$];
    int send_idle;
    int recv_stall;
    int errors;
    int bytes_sent;
    int frames_expected;
    int frames_held;
    int frames_seen;

    function automatic logic [15:0] axis_magnitude(input logic [15:0] w, output logic neg);
        logic [15:0] a;
        neg = w[15];
        a = neg ? (16'd0 - w) : w;
        return {a[13:0], 2'b00};
    endfunction

    function automatic int tilt_degrees(input logic [15:0] mag, input logic [15:0] zmag);
        int a;
        longint unsigned lhs;
        longint unsigned rhs;
        a = 0;
        if (zmag == 16'd0)
            return (mag == 16'd0) ? 0 : ANGLE_STEPS;
        lhs = longint'(mag) << 16;
        for (int k = 1; k < ANGLE_STEPS && k <= TAN_COUNT; k++) begin
            rhs = longint'(TAN_TBL[k-1]) * longint'(zmag);
            if (lhs >= rhs)
                a = k;
            else
                break;
        end
        return a;
    endfunction

    function automatic logic [11:0] clamp_setpoint(input int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'd4095;
        return v[11:0];
    endfunction

    task automatic predict_setpoints(input logic [7:0] b, output bit got, output t_setpoint sp);
        logic xn, yn, zn;
        logic [15:0] xm, ym, zm;
        int c, g, ax, ay;
        got = 1'b0;
        sp = '0;
        if (frame_pos < 5) begin
            frame_store[frame_pos] = b;
            frame_pos++;
            return;
        end
        frame_pos = 0;
        xm = axis_magnitude({frame_store[1], frame_store[0]}, xn);
        ym = axis_magnitude({frame_store[3], frame_store[2]}, yn);
        zm = axis_magnitude({b, frame_store[4]}, zn);
        if (!zn) begin
            c = int'(cur_center);
            g = int'(cur_gain);
            ax = tilt_degrees(xm, zm);
            ay = tilt_degrees(ym, zm);
            hold_one = clamp_setpoint(xn ? c + g * ax : c - g * ax);
            hold_two = clamp_setpoint(yn ? c - g * ay : c + g * ay);
        end
        sp = '{hold_one, hold_two, !zn};
        got = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic feed_byte(input logic [7:0] b, input bit typed, input t_setpoint typed_sp);
        bit got;
        t_setpoint sp;
        send_byte(b);
        predict_setpoints(b, got, sp);
        if (got) begin
            if (typed)
                sp = typed_sp;
            pending_setpoints.push_back(sp);
            frames_expected++;
            if (!sp.updated)
                frames_held++;
        end
    endtask

    // Axis word: mostly random magnitudes at random scales, some corner words.
    function automatic logic [15:0] rand_axis();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 7))
                    0: v = 16'h0000;
                    1: v = 16'h0001;
                    2: v = 16'h4000;
                    3: v = 16'h8000;
                    4: v = 16'hC000;
                    5: v = 16'h7FFF;
                    6: v = 16'hFFFF;
                    default: v = 16'h3FFF;
                endcase
            end
            default: begin
                v = 16'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 15));
                if ($urandom_range(0, 1))
                    v = 16'd0 - v;
            end
        endcase
        return v;
    endfunction

    // z: non-negative four times in five so most frames get recomputed
    function automatic logic [15:0] rand_z();
        logic [15:0] v;
        if ($urandom_range(0, 14) == 0)
            v = $urandom_range(0, 1) ? 16'h4000 : 16'h0000;
        else
            v = 16'($urandom_range(0, 16'h7FFF) >> $urandom_range(0, 14));
        if ($urandom_range(0, 4) == 0)
            v = v | 16'h8000;
        return v;
    endfunction

    task automatic send_frame();
        logic [15:0] x, y, z;
        logic [7:0]  raw [6];
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < 6; i++)
                raw[i] = 8'($urandom_range(0, 255));
        end else begin
            x = rand_axis();
            y = rand_axis();
            z = rand_z();
            raw = '{x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8]};
        end
        for (int i = 0; i < 6; i++)
            feed_byte(raw[i], 1'b0, '0);
    endtask

    task automatic write_reg(input logic [ats_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ats_pkg::SERVO_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == ats_pkg::CFG_CENTER)
            cur_center = data;
        else if (idx == ats_pkg::CFG_GAIN)
            cur_gain = data[3:0];
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        wait (pending_setpoints.size() == 0);
    endtask

    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk)
        servo_ch.ready <= ($urandom_range(0, 99) >= recv_stall);

    always @(posedge i_clk) begin : result_check
        t_setpoint want;
        if (i_rst_n && servo_ch.valid && servo_ch.ready) begin
            frames_seen++;
            if (pending_setpoints.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
            end else begin
                want = pending_setpoints.pop_front();
                if (servo_ch.servo_one !== want.servo_one) begin
                    $error("servo_one: expected %0d, got %0d", want.servo_one,
                           servo_ch.servo_one);
                    errors++;
                end
                if (servo_ch.servo_two !== want.servo_two) begin
                    $error("servo_two: expected %0d, got %0d", want.servo_two,
                           servo_ch.servo_two);
                    errors++;
                end
                if (servo_ch.updated !== want.updated) begin
                    $error("updated: expected %0d, got %0d", want.updated,
                           servo_ch.updated);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d result items still outstanding", pending_setpoints.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic [11:0] p_center [5];
        logic [3:0]  p_gain [5];
        int          p_idle [5];
        int          p_stall [5];
        int          phase_bytes;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'h00;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        errors = 0;
        bytes_sent = 0;
        frames_expected = 0;
        frames_held = 0;
        frames_seen = 0;
        frame_pos  = 0;
        frame_store = '{default: 8'h00};
        hold_one   = 12'd2000;
        hold_two   = 12'd2000;
        cur_center = 12'd2000;
        cur_gain   = 4'd3;

        p_center = '{12'd0, 12'd4095, 12'd4095, 12'($urandom_range(1, 4094)), 12'd1000};
        p_gain   = '{4'd15, 4'd15, 4'd0, 4'($urandom_range(1, 14)), 4'd7};
        p_idle   = '{79, 0, 28, 0, 28};
        p_stall  = '{0, 79, 28, 0, 28};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames at reset register values
        for (int i = 0; i < 24; i++)
            feed_byte(DIR_ROWS[i].rx, DIR_ROWS[i].typed, DIR_ROWS[i].sp);

        for (int p = 0; p < 5; p++) begin
            settle();
            send_idle  = 0;
            recv_stall = 0;
            write_reg(ats_pkg::CFG_CENTER, p_center[p]);
            // upper data bits are don't-care for the gain register
            write_reg(ats_pkg::CFG_GAIN, {8'($urandom_range(0, 255)), p_gain[p]});
            send_idle  = p_idle[p];
            recv_stall = p_stall[p];
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                // hold the sender off until the block has emptied once
                if (p == 3 && phase_bytes == PHASE_BYTES / 2)
                    drain_results();
                send_frame();
                phase_bytes += 6;
            end
        end

        settle();
        $display("Sent %0d bytes, %0d frames (%0d with negative z held), %0d results checked,",
                 bytes_sent, frames_expected, frames_held, frames_seen);
        $display("over reset and five register settings with sender and receiver stalls.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
